FILE: sv/neuron_forward_and_delta_weight_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neuron forward and delta weight block
// Shared property forms used by the modules that carry assertions.
// ----------------------------------------------------------------------------
`ifndef NEURON_FORWARD_AND_DELTA_WEIGHT_DEFINES_SVH
`define NEURON_FORWARD_AND_DELTA_WEIGHT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFDW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFDW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/nfdw_pkg.sv
// ----------------------------------------------------------------------------
// nfdw_pkg
// Types, constants and arithmetic helpers of the neuron forward and delta
// weight block.
// ----------------------------------------------------------------------------
package nfdw_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int ACT_TABLE_DEPTH = 256;

    localparam int DATA_W = 16;
    localparam int CFG_W  = 13;
    localparam int SUM_W  = 40;
    localparam int PROD_W = 2 * DATA_W;
    localparam int X_W    = SUM_W - FRAC_BITS + 1;
    localparam int ARG_W  = X_W + 1;
    localparam int SIG_W  = FRAC_BITS + 1;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int NUM_W  = X_W + FRAC_BITS;
    localparam int T_W    = SIG_W + 2;
    localparam int OPA_W  = DATA_W + 1;
    localparam int MUL_W  = 50;
    localparam int P1_W   = CFG_W + 1 + DATA_W;
    localparam int P2_W   = P1_W + DATA_W - FRAC_BITS;

    localparam int ONE_I  = 1 << FRAC_BITS;
    localparam int GRID_I = (16 * ONE_I) / ACT_TABLE_DEPTH;

    localparam logic [2:0] ACT_STEP    = 3'd0;
    localparam logic [2:0] ACT_TANH    = 3'd1;
    localparam logic [2:0] ACT_SIGMOID = 3'd2;
    localparam logic [2:0] ACT_FAST    = 3'd3;
    localparam logic [2:0] ACT_LEAKY   = 3'd4;

    localparam logic [2:0] REG_ACT_MODE  = 3'd0;
    localparam logic [2:0] REG_STEP_THR  = 3'd1;
    localparam logic [2:0] REG_LEAK      = 3'd2;
    localparam logic [2:0] REG_LEARN     = 3'd3;
    localparam logic [2:0] REG_MOMENTUM  = 3'd4;

    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_DELTA   = 1'b1;

    typedef struct packed {
        logic [2:0]               act_mode;
        logic signed [DATA_W-1:0] step_threshold;
        logic signed [DATA_W-1:0] leak_factor;
        logic [CFG_W-1:0]         learn_rate;
        logic [CFG_W-1:0]         momentum;
    } cfg_t;

    typedef struct packed {
        logic                     kind;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DATA_W-1:0] value;
        logic                     active;
        logic signed [DATA_W-1:0] prior;
        logic signed [DATA_W-1:0] err;
    } req_t;

    function automatic logic signed [MUL_W:0] rshr_round(
        input logic signed [MUL_W:0] v, input int s);
        logic signed [MUL_W:0] half;
        half = (MUL_W + 1)'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [MUL_W:0] v);
        logic signed [MUL_W:0] hi;
        logic signed [MUL_W:0] lo;
        hi = (MUL_W + 1)'(32767);
        lo = -(MUL_W + 1)'(32768);
        if (v > hi) begin
            return DATA_W'(32767);
        end else if (v < lo) begin
            return DATA_W'(-32768);
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [X_W-1:0] round_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0] t;
        t = ({s[SUM_W-1], s} + ((SUM_W + 1)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return t[X_W-1:0];
    endfunction

    // Piecewise-linear sigmoid on an argument quantized to the table grid.
    function automatic logic [SIG_W-1:0] sig_pw(input logic signed [ARG_W-1:0] x);
        logic signed [ARG_W-1:0] lim;
        logic signed [ARG_W-1:0] q;
        logic [ARG_W-1:0]        a;
        logic [ARG_W-1:0]        y;
        lim = ARG_W'(8 * ONE_I);
        if (x < -lim) begin
            q = -lim;
        end else if (x >= lim) begin
            q = lim - ARG_W'(GRID_I);
        end else begin
            q = x & ~ARG_W'(GRID_I - 1);
        end
        a = q[ARG_W-1] ? ARG_W'(-q) : ARG_W'(q);
        if (a >= ARG_W'(5 * ONE_I)) begin
            y = ARG_W'(ONE_I);
        end else if (a >= ARG_W'((19 * ONE_I) / 8)) begin
            y = (a >> 5) + ARG_W'((27 * ONE_I) / 32);
        end else if (a >= ARG_W'(ONE_I)) begin
            y = (a >> 3) + ARG_W'((5 * ONE_I) / 8);
        end else begin
            y = (a >> 2) + ARG_W'(ONE_I / 2);
        end
        if (q[ARG_W-1]) begin
            y = ARG_W'(ONE_I) - y;
        end
        return y[SIG_W-1:0];
    endfunction

endpackage

FILE: sv/nfdw_front.sv
// ----------------------------------------------------------------------------
// nfdw_front
// Accepts input requests, multiplies and accumulates forward terms, and
// queues layer-end and delta requests for the back end.
// ----------------------------------------------------------------------------
module nfdw_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // source_value, link_weight, source_active, prior_delta, neuron_error
    input  logic [71:0]         s_tdata,
    // cmd
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                push,
    output nfdw_pkg::req_t      push_req
);

    typedef enum logic {F_IDLE, F_MAC} fstate_t;

    fstate_t                                   state_reg;
    logic signed [nfdw_pkg::SUM_W-1:0]         sum_reg;
    logic signed [nfdw_pkg::PROD_W-1:0]        prod_reg;
    logic                                      cmd_reg;
    logic                                      last_reg;
    logic                                      active_reg;
    logic signed [nfdw_pkg::DATA_W-1:0]        value_reg;
    logic signed [nfdw_pkg::DATA_W-1:0]        prior_reg;
    logic signed [nfdw_pkg::DATA_W-1:0]        err_reg;
    logic signed [nfdw_pkg::SUM_W:0]           sum_wide;
    logic signed [nfdw_pkg::SUM_W-1:0]         sum_next;
    logic                                      accept;

    assign s_tready = (state_reg == F_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        sum_wide = {sum_reg[nfdw_pkg::SUM_W-1], sum_reg}
                 + (nfdw_pkg::SUM_W + 1)'(prod_reg);
        if (cmd_reg == nfdw_pkg::KIND_DELTA || !active_reg) begin
            sum_next = sum_reg;
        end else if (sum_wide[nfdw_pkg::SUM_W] != sum_wide[nfdw_pkg::SUM_W-1]) begin
            sum_next = sum_wide[nfdw_pkg::SUM_W]
                     ? {1'b1, {(nfdw_pkg::SUM_W-1){1'b0}}}
                     : {1'b0, {(nfdw_pkg::SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[nfdw_pkg::SUM_W-1:0];
        end
    end

    assign push = (state_reg == F_MAC) && (cmd_reg == nfdw_pkg::KIND_DELTA || last_reg);

    always_comb begin
        push_req.kind   = cmd_reg;
        push_req.sum    = sum_next;
        push_req.value  = value_reg;
        push_req.active = active_reg;
        push_req.prior  = prior_reg;
        push_req.err    = err_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            sum_reg   <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        state_reg <= F_MAC;
                    end
                end
                F_MAC: begin
                    state_reg <= F_IDLE;
                    if (cmd_reg == nfdw_pkg::KIND_FORWARD) begin
                        sum_reg <= last_reg ? '0 : sum_next;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
        if (accept) begin
            cmd_reg    <= s_tuser;
            last_reg   <= s_tlast;
            value_reg  <= $signed(s_tdata[15:0]);
            active_reg <= s_tdata[32];
            prior_reg  <= $signed(s_tdata[48:33]);
            err_reg    <= $signed(s_tdata[64:49]);
            prod_reg   <= $signed(s_tdata[15:0]) * $signed(s_tdata[31:16]);
        end
    end

endmodule

FILE: sv/nfdw_queue.sv
// ----------------------------------------------------------------------------
// nfdw_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "neuron_forward_and_delta_weight_defines.svh"

module nfdw_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_i,
    input  nfdw_pkg::req_t      push_req_i,
    output logic                full_o,
    input  logic                pop_i,
    output logic                valid_o,
    output nfdw_pkg::req_t      head_o
);

    nfdw_pkg::req_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full_o  = count_reg == 2'd2;
    assign valid_o = count_reg != 2'd0;
    assign head_o  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_i) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_i && !pop_i) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop_i && !push_i) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= push_req_i;
        end
    end

    `NFDW_ASSERT_NOW(a_push_not_full, aclk, aresetn, push_i, !full_o, "push into a full queue")
    `NFDW_ASSERT_NOW(a_pop_not_empty, aclk, aresetn, pop_i, valid_o, "pop from an empty queue")
    `NFDW_ASSERT_NEXT(a_count_up, aclk, aresetn, push_i && !pop_i, count_reg == $past(count_reg) + 2'd1, "queue count did not rise on push")

endmodule

FILE: sv/nfdw_div.sv
// ----------------------------------------------------------------------------
// nfdw_div
// Restoring divider producing one quotient bit per cycle for the
// fast sigmoid activation.
// ----------------------------------------------------------------------------
module nfdw_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [nfdw_pkg::NUM_W-1:0]    num,
    input  logic [nfdw_pkg::X_W-1:0]      den,
    output logic                          done,
    output logic [nfdw_pkg::QUO_W-1:0]    quo
);

    localparam int CNT_W = $clog2(nfdw_pkg::QUO_W + 1);
    localparam int LOW_W = nfdw_pkg::QUO_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [nfdw_pkg::X_W-1:0]      rem_reg;
    logic [nfdw_pkg::X_W-1:0]      den_reg;
    logic [LOW_W-1:0]              low_reg;
    logic [nfdw_pkg::QUO_W-1:0]    quo_reg;
    logic [nfdw_pkg::X_W:0]        trial;
    logic                          fits;

    assign trial = {rem_reg, low_reg[LOW_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && cnt_reg == CNT_W'(1);
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(nfdw_pkg::QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
        if (start && !busy_reg) begin
            rem_reg <= nfdw_pkg::X_W'(num >> nfdw_pkg::QUO_W);
            low_reg <= num[LOW_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? nfdw_pkg::X_W'(trial - {1'b0, den_reg})
                            : trial[nfdw_pkg::X_W-1:0];
            low_reg <= {low_reg[LOW_W-2:0], 1'b0};
            quo_reg <= {quo_reg[nfdw_pkg::QUO_W-2:0], fits};
        end
    end

endmodule

FILE: sv/nfdw_back.sv
// ----------------------------------------------------------------------------
// nfdw_back
// Sequencer that computes activations, derivatives and delta weights with
// one shared multiplier and drives the result register.
// ----------------------------------------------------------------------------
module nfdw_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  nfdw_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  nfdw_pkg::req_t      q_head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    // activation, derivative, delta_weight
    output logic [47:0]         m_tdata,
    // kind
    output logic                m_tuser
);

    localparam int FB = nfdw_pkg::FRAC_BITS;
    localparam int MW = nfdw_pkg::MUL_W;
    localparam int DW = nfdw_pkg::DATA_W;

    typedef enum logic [3:0] {
        B_IDLE, B_ACT1, B_DIV1, B_DIV2, B_ACT2, B_ACT3,
        B_DW1, B_DW2, B_DW3, B_DW4, B_DW5, B_DW6, B_DW7, B_OUT
    } bstate_t;

    bstate_t                                 state_reg;
    logic                                    kind_reg;
    logic signed [nfdw_pkg::X_W-1:0]         x_reg;
    logic signed [DW-1:0]                    value_reg;
    logic signed [DW-1:0]                    prior_reg;
    logic signed [DW-1:0]                    err_reg;
    logic                                    active_reg;
    logic [nfdw_pkg::SIG_W-1:0]              s_reg;
    logic [nfdw_pkg::QUO_W-1:0]              r1_reg;
    logic [nfdw_pkg::QUO_W-1:0]              r2_reg;
    logic signed [MW-1:0]                    mul_reg;
    logic signed [MW-1:0]                    tmp_reg;
    logic signed [DW-1:0]                    act_reg;
    logic signed [DW-1:0]                    der_reg;
    logic signed [DW-1:0]                    dw_reg;
    logic signed [DW-1:0]                    held_der_reg;
    logic                                    m_valid_reg;
    logic [47:0]                             m_data_reg;
    logic                                    m_user_reg;

    logic [nfdw_pkg::X_W-1:0]                ax;
    logic [nfdw_pkg::X_W-1:0]                den;
    logic [nfdw_pkg::NUM_W-1:0]              div_num;
    logic                                    div_start;
    logic                                    div_done;
    logic [nfdw_pkg::QUO_W-1:0]              div_quo;
    logic signed [nfdw_pkg::ARG_W-1:0]       sig_arg;
    logic [nfdw_pkg::SIG_W-1:0]              sig_val;
    logic signed [nfdw_pkg::T_W-1:0]         t_val;
    logic signed [nfdw_pkg::OPA_W-1:0]       op_a;
    logic signed [nfdw_pkg::ARG_W-1:0]       op_b;
    logic signed [MW:0]                      rnd_fb;
    logic signed [MW:0]                      rnd_2fb;
    logic signed [MW:0]                      x_ext;
    logic signed [MW:0]                      dw_sum;
    logic signed [DW-1:0]                    act_c;
    logic signed [DW-1:0]                    der_c;
    logic                                    out_free;

    assign pop      = (state_reg == B_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        ax      = x_reg[nfdw_pkg::X_W-1] ? nfdw_pkg::X_W'(-x_reg) : nfdw_pkg::X_W'(x_reg);
        den     = nfdw_pkg::X_W'(nfdw_pkg::ONE_I) + ax;
        div_num = (state_reg == B_ACT1) ? {ax, {FB{1'b0}}}
                                        : nfdw_pkg::NUM_W'(1) << (2 * FB);
        div_start = ((state_reg == B_ACT1) && (cfg.act_mode == nfdw_pkg::ACT_FAST))
                 || ((state_reg == B_DIV1) && div_done);
        sig_arg = (cfg.act_mode == nfdw_pkg::ACT_TANH) ? {x_reg, 1'b0}
                                                       : {x_reg[nfdw_pkg::X_W-1], x_reg};
        sig_val = nfdw_pkg::sig_pw(sig_arg);
        t_val   = $signed({1'b0, s_reg, 1'b0}) - $signed(nfdw_pkg::T_W'(nfdw_pkg::ONE_I));
        x_ext   = (MW + 1)'(x_reg);
        rnd_fb  = nfdw_pkg::rshr_round({mul_reg[MW-1], mul_reg}, FB);
        rnd_2fb = nfdw_pkg::rshr_round({mul_reg[MW-1], mul_reg}, 2 * FB);
        dw_sum  = {tmp_reg[MW-1], tmp_reg} + rnd_fb;
    end

    always_comb begin
        case (cfg.act_mode)
            nfdw_pkg::ACT_TANH: begin
                op_a = nfdw_pkg::OPA_W'(t_val);
                op_b = nfdw_pkg::ARG_W'(t_val);
            end
            nfdw_pkg::ACT_FAST: begin
                op_a = $signed(nfdw_pkg::OPA_W'(r2_reg));
                op_b = $signed(nfdw_pkg::ARG_W'(r2_reg));
            end
            nfdw_pkg::ACT_LEAKY: begin
                op_a = nfdw_pkg::OPA_W'(cfg.leak_factor);
                op_b = nfdw_pkg::ARG_W'(x_reg);
            end
            default: begin
                op_a = $signed(nfdw_pkg::OPA_W'(s_reg));
                op_b = $signed(nfdw_pkg::ARG_W'(nfdw_pkg::ONE_I) - nfdw_pkg::ARG_W'(s_reg));
            end
        endcase
    end

    always_comb begin
        case (cfg.act_mode)
            nfdw_pkg::ACT_STEP: begin
                act_c = (x_ext > (MW + 1)'(cfg.step_threshold)) ? DW'(nfdw_pkg::ONE_I) : '0;
                der_c = nfdw_pkg::sat16(rnd_fb);
            end
            nfdw_pkg::ACT_TANH: begin
                act_c = DW'(t_val);
                der_c = nfdw_pkg::sat16((MW + 1)'(nfdw_pkg::ONE_I) - rnd_fb);
            end
            nfdw_pkg::ACT_SIGMOID: begin
                act_c = DW'(s_reg);
                der_c = nfdw_pkg::sat16(rnd_fb);
            end
            nfdw_pkg::ACT_FAST: begin
                act_c = x_reg[nfdw_pkg::X_W-1] ? -DW'(r1_reg) : DW'(r1_reg);
                der_c = nfdw_pkg::sat16(rnd_fb);
            end
            nfdw_pkg::ACT_LEAKY: begin
                if (x_reg[nfdw_pkg::X_W-1]) begin
                    act_c = nfdw_pkg::sat16(rnd_fb);
                    der_c = cfg.leak_factor;
                end else begin
                    act_c = nfdw_pkg::sat16(x_ext);
                    der_c = DW'(nfdw_pkg::ONE_I);
                end
            end
            default: begin
                act_c = '0;
                der_c = '0;
            end
        endcase
    end

    nfdw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            held_der_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if ((state_reg == B_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        state_reg <= (q_head.kind == nfdw_pkg::KIND_DELTA) ? B_DW1 : B_ACT1;
                    end
                end
                B_ACT1: begin
                    state_reg <= (cfg.act_mode == nfdw_pkg::ACT_FAST) ? B_DIV1 : B_ACT2;
                end
                B_DIV1: begin
                    if (div_done) begin
                        state_reg <= B_DIV2;
                    end
                end
                B_DIV2: begin
                    if (div_done) begin
                        state_reg <= B_ACT2;
                    end
                end
                B_ACT2: state_reg <= B_ACT3;
                B_ACT3: begin
                    held_der_reg <= der_c;
                    state_reg    <= B_OUT;
                end
                B_DW1: state_reg <= active_reg ? B_DW2 : B_OUT;
                B_DW2: state_reg <= B_DW3;
                B_DW3: state_reg <= B_DW4;
                B_DW4: state_reg <= B_DW5;
                B_DW5: state_reg <= B_DW6;
                B_DW6: state_reg <= B_DW7;
                B_DW7: state_reg <= B_OUT;
                B_OUT: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end

        unique case (state_reg)
            B_IDLE: begin
                kind_reg   <= q_head.kind;
                x_reg      <= nfdw_pkg::round_sum(q_head.sum);
                value_reg  <= q_head.value;
                prior_reg  <= q_head.prior;
                err_reg    <= q_head.err;
                active_reg <= q_head.active;
                act_reg    <= '0;
                der_reg    <= '0;
                dw_reg     <= '0;
            end
            B_ACT1: s_reg <= sig_val;
            B_DIV1: begin
                if (div_done) begin
                    r1_reg <= div_quo;
                end
            end
            B_DIV2: begin
                if (div_done) begin
                    r2_reg <= div_quo;
                end
            end
            B_ACT2: mul_reg <= MW'(op_a * op_b);
            B_ACT3: begin
                act_reg <= act_c;
                der_reg <= der_c;
            end
            B_DW1: begin
                mul_reg <= MW'($signed({1'b0, cfg.learn_rate}) * err_reg);
                if (!active_reg) begin
                    dw_reg <= prior_reg;
                end
            end
            B_DW2: mul_reg <= MW'($signed(mul_reg[nfdw_pkg::P1_W-1:0]) * held_der_reg);
            B_DW3: tmp_reg <= rnd_fb[MW-1:0];
            B_DW4: mul_reg <= MW'($signed(tmp_reg[nfdw_pkg::P2_W-1:0]) * value_reg);
            B_DW5: tmp_reg <= rnd_2fb[MW-1:0];
            B_DW6: mul_reg <= MW'($signed({1'b0, cfg.momentum}) * prior_reg);
            B_DW7: dw_reg  <= nfdw_pkg::sat16(dw_sum);
            B_OUT: begin
                if (out_free) begin
                    m_data_reg <= {dw_reg, der_reg, act_reg};
                    m_user_reg <= kind_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: sv/neuron_forward_and_delta_weight.sv
// ----------------------------------------------------------------------------
// neuron_forward_and_delta_weight
// Single neuron with forward multiply-accumulate, activation and momentum
// delta-weight computation.
// ----------------------------------------------------------------------------
// The front end cannot take a new request before it is done with the last:
// a 16x16 product in the accept cycle and a saturating 40-bit accumulate in
// the next. Forward terms that are not last give no result. Layer-end and
// delta requests pass through a two-entry queue to a back-end sequencer
// that shares one multiplier. A layer-end request passes the states ACT1,
// ACT2 and ACT3 before the output handoff; fast sigmoid adds two divisions
// in the restoring divider between ACT1 and ACT2. A delta request runs the
// states DW1 to DW7, or DW1 alone when the source is inactive. The input
// side keeps accepting while the back end works, until the queue is full.
module neuron_forward_and_delta_weight (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // source_value, link_weight, source_active, prior_delta, neuron_error
    input  logic [71:0]  s_tdata,
    // cmd
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // activation, derivative, delta_weight
    output logic [47:0]  m_tdata,
    // kind
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    nfdw_pkg::cfg_t cfg_reg;
    nfdw_pkg::req_t push_req;
    nfdw_pkg::req_t q_head;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    logic           cfg_wr;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.act_mode       <= nfdw_pkg::ACT_SIGMOID;
            cfg_reg.step_threshold <= 16'sd2048;
            cfg_reg.leak_factor    <= '0;
            cfg_reg.learn_rate     <= 13'd410;
            cfg_reg.momentum       <= 13'd2048;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                nfdw_pkg::REG_ACT_MODE: cfg_reg.act_mode       <= pwdata[2:0];
                nfdw_pkg::REG_STEP_THR: cfg_reg.step_threshold <= $signed(pwdata[15:0]);
                nfdw_pkg::REG_LEAK:     cfg_reg.leak_factor    <= $signed(pwdata[15:0]);
                nfdw_pkg::REG_LEARN:    cfg_reg.learn_rate     <= pwdata[12:0];
                nfdw_pkg::REG_MOMENTUM: cfg_reg.momentum       <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            nfdw_pkg::REG_ACT_MODE: prdata = 32'(cfg_reg.act_mode);
            nfdw_pkg::REG_STEP_THR: prdata = 32'(unsigned'(cfg_reg.step_threshold));
            nfdw_pkg::REG_LEAK:     prdata = 32'(unsigned'(cfg_reg.leak_factor));
            nfdw_pkg::REG_LEARN:    prdata = 32'(cfg_reg.learn_rate);
            nfdw_pkg::REG_MOMENTUM: prdata = 32'(cfg_reg.momentum);
            default:                prdata = '0;
        endcase
    end

    nfdw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_req (push_req)
    );

    nfdw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_i     (push),
        .push_req_i (push_req),
        .full_o     (q_full),
        .pop_i      (pop),
        .valid_o    (q_valid),
        .head_o     (q_head)
    );

    nfdw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
